>>> hw/rtl/plc_pkg.sv
// Shared types and constants of the piecewise-linear curve evaluator.
`default_nettype none

package plc_pkg;

  localparam int POS_W     = 17;                // unsigned Q1.16 position
  localparam int LVL_W     = 32;                // signed Q15.16 level
  localparam int KNOT_W    = POS_W + LVL_W;     // one knot table word
  localparam int DIFF_W    = LVL_W + 1;         // level difference
  localparam int PROD_W    = DIFF_W + POS_W + 1; // signed product
  localparam int MAG_W     = PROD_W - 1;        // product magnitude
  localparam int QUOT_W    = DIFF_W + 1;        // quotient bits kept
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FINISH = 2'd2,
    OP_EVAL   = 2'd3
  } plc_opcode_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TOO_FEW        = 3'd1,
    ST_TOO_MANY       = 3'd2,
    ST_NOT_INCREASING = 3'd3,
    ST_NOT_MONOTONIC  = 3'd4,
    ST_NO_GRAPH       = 3'd5
  } plc_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_CHK,
    S_EV_RD,
    S_EV_CHK,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PUSH
  } plc_state_t;

  typedef struct packed {
    plc_opcode_t              opcode;
    logic [POS_W-1:0]         position;
    logic signed [LVL_W-1:0]  level;
    logic                     mono_required;
  } plc_cmd_t;

  typedef struct packed {
    plc_status_t              status;
    logic signed [LVL_W-1:0]  value;
    logic                     graph_monotonic;
    logic                     graph_ready;
  } plc_result_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [POS_W-1:0]  divisor;
  } plc_div_req_t;

  typedef struct packed {
    logic              done;
    logic [MAG_W-1:0]  quotient;
  } plc_div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/plc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface plc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module plc_divider
  import plc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  plc_div_req_t req,
  output plc_div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [POS_W-1:0]      rem;
  logic [POS_W-1:0]      dsr;
  logic [MAG_W-1:0]      dvd;
  logic [POS_W:0]        trial;
  logic                  fits;

  // trial subtract of the next dividend bit
  assign trial = {rem, dvd[MAG_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(MAG_W);
        rem  <= '0;
        dsr  <= req.divisor;
        dvd  <= req.dividend;
      end else if (busy) begin
        rem <= fits ? POS_W'(trial - {1'b0, dsr}) : POS_W'(trial);
        dvd <= {dvd[MAG_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // dividend register turns into the quotient as bits shift in
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire

>>> hw/rtl/piecewise_linear_curve.sv
// Piecewise-linear curve evaluator: knot table in RAM, serial segment scan, serial divide.
// Command path: clear, finish, evaluate without a graph and append to a full table go
//   straight to the push state; append reads the last knot, checks it and pushes; evaluate
//   scans knot by knot, then for an inner point multiplies, runs the divider and pushes.
// Throughput: one command at a time; the next is taken the cycle after its result is loaded.
// Reset (synchronous, rst high): empty table, flags cleared, levels_rising set; knot RAM is not cleared.
`default_nettype none

module piecewise_linear_curve
  import plc_pkg::*;
#(
  parameter int MAX_KNOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  plc_stream_if.sink   cmd,
  plc_stream_if.source result
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_KNOTS);
  localparam logic [CW-1:0] MIN_KNOTS = CW'(2);

  plc_state_t state, state_next;

  // table bookkeeping
  logic [CW-1:0] knot_total;
  logic          overflowed;
  logic          order_broken;
  logic          levels_rising;
  logic          ready_flag;
  logic          monotonic_flag;

  // latched command
  logic [POS_W-1:0]        q_pos;
  logic signed [LVL_W-1:0] in_lvl;
  logic [AW-1:0]           idx;

  // segment endpoints and arithmetic
  logic [POS_W-1:0]         prev_pos, cur_pos, span;
  logic signed [LVL_W-1:0]  prev_lvl, cur_lvl;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIFF_W-1:0] diff;
  logic signed [POS_W:0]    off;
  logic [PROD_W-1:0]        prod_neg;
  logic [QUOT_W-1:0]        q_mag, q_signed;
  logic [QUOT_W-1:0]        interp;

  plc_status_t             res_status;
  logic signed [LVL_W-1:0] res_value;
  plc_status_t             fin_status;

  // knot RAM
  logic              wr_en, rd_en;
  logic [KNOT_W-1:0] rd_data;
  logic [POS_W-1:0]  rd_pos;
  logic signed [LVL_W-1:0] rd_lvl;

  plc_div_req_t div_req;
  plc_div_rsp_t div_rsp;

  logic          accept, out_free, hit, at_last;
  logic [CW-1:0] last_idx;

  plc_ram #(
    .WIDTH (KNOT_W),
    .DEPTH (MAX_KNOTS)
  ) u_knots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(knot_total)),
    .wr_data ({q_pos, in_lvl}),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  plc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign rd_pos   = rd_data[KNOT_W-1:LVL_W];
  assign rd_lvl   = rd_data[LVL_W-1:0];
  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !result.valid || result.ready;
  assign hit      = q_pos <= rd_pos;
  assign last_idx = knot_total - CW'(1);
  assign at_last  = CW'(idx) == last_idx;

  // interpolation arithmetic
  assign diff     = DIFF_W'(cur_lvl) - DIFF_W'(prev_lvl);
  assign off      = $signed({1'b0, POS_W'(q_pos - prev_pos)});
  assign prod_neg = PROD_W'(-prod);
  assign q_mag    = div_rsp.quotient[QUOT_W-1:0];
  assign q_signed = prod[PROD_W-1] ? QUOT_W'(-q_mag) : q_mag;
  assign interp   = QUOT_W'($signed(prev_lvl)) + q_signed;

  assign div_req.start    = state == S_DIV_GO;
  assign div_req.dividend = prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
  assign div_req.divisor  = span;

  // finish checks in priority order
  always_comb begin
    if (knot_total < MIN_KNOTS) begin
      fin_status = ST_TOO_FEW;
    end else if (overflowed) begin
      fin_status = ST_TOO_MANY;
    end else if (order_broken) begin
      fin_status = ST_NOT_INCREASING;
    end else if (cmd.data.mono_required && !levels_rising) begin
      fin_status = ST_NOT_MONOTONIC;
    end else begin
      fin_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.data.opcode)
            OP_APPEND: state_next = (knot_total >= FULL) ? S_PUSH : S_APP_RD;
            OP_EVAL: begin
              state_next = (!ready_flag || knot_total < MIN_KNOTS) ? S_PUSH : S_EV_RD;
            end
            default:   state_next = S_PUSH;
          endcase
        end
      end
      S_APP_RD:  state_next = S_APP_CHK;
      S_APP_CHK: state_next = S_PUSH;
      S_EV_RD:   state_next = S_EV_CHK;
      S_EV_CHK: begin
        if (idx == '0) begin
          state_next = hit ? S_PUSH : S_EV_RD;
        end else if (hit) begin
          state_next = S_MUL;
        end else begin
          state_next = at_last ? S_PUSH : S_EV_RD;
        end
      end
      S_MUL:      state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: state_next = div_rsp.done ? S_PUSH : S_DIV_WAIT;
      S_PUSH:     state_next = out_free ? S_IDLE : S_PUSH;
      default:    state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd.ready = state == S_IDLE;
    rd_en     = (state == S_APP_RD) || (state == S_EV_RD);
    wr_en     = state == S_APP_CHK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      knot_total     <= '0;
      overflowed     <= 1'b0;
      order_broken   <= 1'b0;
      levels_rising  <= 1'b1;
      ready_flag     <= 1'b0;
      monotonic_flag <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      state <= state_next;

      // output register: load a new beat or drop the one taken
      if (state == S_PUSH && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            q_pos      <= cmd.data.position;
            in_lvl     <= cmd.data.level;
            res_status <= ST_OK;
            res_value  <= '0;
            case (cmd.data.opcode)
              OP_CLEAR: begin
                knot_total     <= '0;
                overflowed     <= 1'b0;
                order_broken   <= 1'b0;
                levels_rising  <= 1'b1;
                ready_flag     <= 1'b0;
                monotonic_flag <= 1'b0;
              end
              OP_APPEND: begin
                ready_flag     <= 1'b0;
                monotonic_flag <= 1'b0;
                idx            <= AW'(last_idx);
                if (knot_total >= FULL) begin
                  overflowed <= 1'b1;
                end
              end
              OP_FINISH: begin
                res_status     <= fin_status;
                ready_flag     <= fin_status == ST_OK;
                monotonic_flag <= (fin_status == ST_OK) && levels_rising;
              end
              default: begin
                idx <= '0;
                if (!ready_flag || knot_total < MIN_KNOTS) begin
                  res_status <= ST_NO_GRAPH;
                end
              end
            endcase
          end
        end
        // compare against the last stored knot, RAM write happens this cycle
        S_APP_CHK: begin
          if (knot_total != '0) begin
            if (q_pos <= rd_pos) begin
              order_broken <= 1'b1;
            end
            if (in_lvl < rd_lvl) begin
              levels_rising <= 1'b0;
            end
          end
          knot_total <= knot_total + CW'(1);
        end
        // serial segment search
        S_EV_CHK: begin
          if (hit) begin
            if (idx == '0) begin
              res_value <= rd_lvl;
            end else begin
              cur_pos <= rd_pos;
              cur_lvl <= rd_lvl;
            end
          end else if (idx != '0 && at_last) begin
            res_value <= rd_lvl;
          end else begin
            prev_pos <= rd_pos;
            prev_lvl <= rd_lvl;
            idx      <= idx + AW'(1);
          end
        end
        S_MUL: begin
          prod <= PROD_W'(diff * off);
          span <= cur_pos - prev_pos;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_value <= interp[LVL_W-1:0];
          end
        end
        S_PUSH: begin
          if (out_free) begin
            result.data.status          <= res_status;
            result.data.value           <= res_value;
            result.data.graph_monotonic <= monotonic_flag;
            result.data.graph_ready     <= ready_flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    knot_total <= FULL)
    else $error("knot count beyond table depth");

  a_ready_consistent: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> (knot_total >= MIN_KNOTS && !overflowed && !order_broken))
    else $error("graph ready on an invalid table");

  a_mono_consistent: assert property (@(posedge clk) disable iff (rst)
    monotonic_flag |-> (ready_flag && levels_rising))
    else $error("monotonic flag without a rising ready graph");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside the wait state");

  a_push_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_free) |=> result.valid)
    else $error("result not loaded into the output register");
`endif

endmodule

`default_nettype wire
